>>> hw/rtl/rept_pkg.sv
package rept_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef logic [1:0] dir_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam dir_type DIR_NONE = 2'd0;
   localparam dir_type DIR_DEC  = 2'd1;
   localparam dir_type DIR_INC  = 2'd2;

   localparam csr_index_type CSR_ACTIVE_LEVEL   = 3'd0;
   localparam csr_index_type CSR_DEBOUNCE_MS    = 3'd1;
   localparam csr_index_type CSR_ERROR_HOLD_MS  = 3'd2;
   localparam csr_index_type CSR_LIMIT_ENABLE   = 3'd3;
   localparam csr_index_type CSR_LOWER_LIMIT    = 3'd4;
   localparam csr_index_type CSR_UPPER_LIMIT    = 3'd5;
   localparam csr_index_type CSR_STEP_SIZE      = 3'd6;
   localparam csr_index_type CSR_START_POSITION = 3'd7;

   localparam logic        RST_ACTIVE_LEVEL  = 1'b1;
   localparam logic [15:0] RST_DEBOUNCE_MS   = 16'd2;
   localparam logic [15:0] RST_ERROR_HOLD_MS = 16'd200;
   localparam logic        RST_LIMIT_ENABLE  = 1'b0;
   localparam logic [15:0] RST_LOWER_LIMIT   = 16'h8000;
   localparam logic [15:0] RST_UPPER_LIMIT   = 16'h7fff;
   localparam logic [14:0] RST_STEP_SIZE     = 15'd1;
   localparam logic [15:0] RST_POSITION      = 16'd0;

endpackage

>>> hw/rtl/rotary_encoder_position_tracker_top.sv
// an accepted item passes the input register, then the result register; a result stall can hold it between them
// throughput: one item per cycle while the result is not stalled; input register and result register in one pass
// a stalled result holds the input register, which still fills once
// reset: synchronous, active high; control, configuration and tracker registers return to defaults, position to zero
// a start_position write is ignored; reset restores the position to zero
module rotary_encoder_position_tracker_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [31:0]                       req_time_ms,
   input  logic                              req_pin_a,
   input  logic                              req_pin_b,
   input  logic                              req_enable,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_direction,
   output logic signed [15:0]                rsp_position,
   output logic signed [15:0]                rsp_previous_position,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rept_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rept_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration
   logic        active_level_ff;
   logic [15:0] debounce_ms_ff;
   logic [15:0] error_hold_ms_ff;
   logic        limit_enable_ff;
   logic signed [15:0] lower_limit_ff;
   logic signed [15:0] upper_limit_ff;
   logic [14:0] step_size_ff;

   // input stage
   logic        in_valid_ff;
   logic [31:0] in_time_ff;
   logic        in_pin_a_ff;
   logic        in_pin_b_ff;
   logic        in_enable_ff;

   // tracker state
   logic        prev_a_ff, prev_a_in;
   rept_pkg::dir_type held_dir_ff, held_dir_in;
   logic [31:0] sample_stamp_ff, sample_stamp_in;
   logic [31:0] edge_stamp_ff, edge_stamp_in;
   logic signed [15:0] position_ff, position_in;
   logic signed [15:0] previous_position_ff, previous_position_in;

   // result stage
   logic        out_valid_ff;
   rept_pkg::dir_type out_dir_ff;

   logic        advance;
   logic        req_take;
   logic [31:0] sample_elapsed;
   logic [31:0] edge_elapsed;
   logic        sampled;
   logic        a_asserted;
   logic        b_asserted;
   logic        fall_edge;
   logic        in_hold;
   rept_pkg::dir_type raw_dir;
   rept_pkg::dir_type dir_w;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff  <= rept_pkg::RST_ACTIVE_LEVEL;
         debounce_ms_ff   <= rept_pkg::RST_DEBOUNCE_MS;
         error_hold_ms_ff <= rept_pkg::RST_ERROR_HOLD_MS;
         limit_enable_ff  <= rept_pkg::RST_LIMIT_ENABLE;
         lower_limit_ff   <= rept_pkg::RST_LOWER_LIMIT;
         upper_limit_ff   <= rept_pkg::RST_UPPER_LIMIT;
         step_size_ff     <= rept_pkg::RST_STEP_SIZE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rept_pkg::CSR_ACTIVE_LEVEL:   active_level_ff  <= csr_wdata[0];
            rept_pkg::CSR_DEBOUNCE_MS:    debounce_ms_ff   <= csr_wdata;
            rept_pkg::CSR_ERROR_HOLD_MS:  error_hold_ms_ff <= csr_wdata;
            rept_pkg::CSR_LIMIT_ENABLE:   limit_enable_ff  <= csr_wdata[0];
            rept_pkg::CSR_LOWER_LIMIT:    lower_limit_ff   <= csr_wdata;
            rept_pkg::CSR_UPPER_LIMIT:    upper_limit_ff   <= csr_wdata;
            rept_pkg::CSR_STEP_SIZE:      step_size_ff     <= csr_wdata[14:0];
            rept_pkg::CSR_START_POSITION: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      sample_elapsed = in_time_ff - sample_stamp_ff;
      edge_elapsed   = in_time_ff - edge_stamp_ff;
      sampled        = sample_elapsed >= {16'd0, debounce_ms_ff};
      a_asserted     = in_pin_a_ff == active_level_ff;
      b_asserted     = in_pin_b_ff == active_level_ff;
      fall_edge      = sampled && !a_asserted && prev_a_ff;
      in_hold        = edge_elapsed < {16'd0, error_hold_ms_ff};
      raw_dir        = b_asserted ? rept_pkg::DIR_DEC : rept_pkg::DIR_INC;

      dir_w           = rept_pkg::DIR_NONE;
      prev_a_in       = prev_a_ff;
      held_dir_in     = held_dir_ff;
      sample_stamp_in = sample_stamp_ff;
      edge_stamp_in   = edge_stamp_ff;
      if (sampled) begin
         prev_a_in       = a_asserted;
         sample_stamp_in = in_time_ff;
      end
      if (fall_edge) begin
         edge_stamp_in = in_time_ff;
         if (in_hold) begin
            dir_w = held_dir_ff;
         end else begin
            dir_w       = raw_dir;
            held_dir_in = raw_dir;
         end
      end

      position_in          = position_ff;
      previous_position_in = previous_position_ff;
      if (in_enable_ff) begin
         case (dir_w)
            rept_pkg::DIR_NONE: previous_position_in = position_ff;
            rept_pkg::DIR_DEC: begin
               if (!limit_enable_ff || position_ff > lower_limit_ff) begin
                  position_in = position_ff - $signed({1'b0, step_size_ff});
               end
            end
            rept_pkg::DIR_INC: begin
               if (!limit_enable_ff || position_ff < upper_limit_ff) begin
                  position_in = position_ff + $signed({1'b0, step_size_ff});
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         prev_a_ff            <= 1'b0;
         held_dir_ff          <= rept_pkg::DIR_NONE;
         sample_stamp_ff      <= 32'd0;
         edge_stamp_ff        <= 32'd0;
         position_ff          <= rept_pkg::RST_POSITION;
         previous_position_ff <= 16'sd0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff         <= 1'b1;
            prev_a_ff            <= prev_a_in;
            held_dir_ff          <= held_dir_in;
            sample_stamp_ff      <= sample_stamp_in;
            edge_stamp_ff        <= edge_stamp_in;
            position_ff          <= position_in;
            previous_position_ff <= previous_position_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_time_ff   <= req_time_ms;
         in_pin_a_ff  <= req_pin_a;
         in_pin_b_ff  <= req_pin_b;
         in_enable_ff <= req_enable;
      end
      if (advance) begin
         out_dir_ff <= dir_w;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_direction         = out_dir_ff;
   assign rsp_position          = position_ff;
   assign rsp_previous_position = previous_position_ff;

`ifndef NO_ASSERTIONS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   a_disabled_holds_position: assert property (@(posedge clock) disable iff (reset)
      advance && !in_enable_ff |=> position_ff == $past(position_ff)
         && previous_position_ff == $past(previous_position_ff))
      else $error("position moved on a disabled item");

   a_no_turn_latches: assert property (@(posedge clock) disable iff (reset)
      advance && in_enable_ff && dir_w == rept_pkg::DIR_NONE
         |=> previous_position_ff == $past(position_ff))
      else $error("previous position not latched on an item with no turn");

   a_turn_needs_sample: assert property (@(posedge clock) disable iff (reset)
      advance && !sampled |=> rsp_direction == rept_pkg::DIR_NONE
         && sample_stamp_ff == $past(sample_stamp_ff))
      else $error("turn reported inside debounce");
`endif

endmodule

>>> test/rotary_encoder_position_tracker_top_test.sv
`timescale 1ns / 100ps

module rotary_encoder_position_tracker_top_test;

   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef struct packed {
      rept_pkg::dir_type direction;
      logic [15:0]       position;
      logic [15:0]       previous;
   } poll_result_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [31:0]               req_time_ms;
   logic                      req_pin_a;
   logic                      req_pin_b;
   logic                      req_enable;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_direction;
   logic signed [15:0]        rsp_position;
   logic signed [15:0]        rsp_previous_position;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [rept_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [rept_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   // register copies
   logic        cfg_active;
   logic [15:0] cfg_debounce;
   logic [15:0] cfg_hold;
   logic        cfg_limit_en;
   logic [15:0] cfg_lower;
   logic [15:0] cfg_upper;
   logic [14:0] cfg_step;

   // tracker state copies
   logic              a_was_on;
   rept_pkg::dir_type held_dir;
   logic [31:0]       sample_ms;
   logic [31:0]       edge_ms;
   logic [15:0]       position_now;
   logic [15:0]       position_kept;

   poll_result_type expected_polls[$];
   poll_result_type next_result;
   logic [31:0]  clock_ms;
   bit           quiet;
   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;
   int unsigned  stall_left = 0;

   rotary_encoder_position_tracker_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_time_ms          (req_time_ms),
      .req_pin_a            (req_pin_a),
      .req_pin_b            (req_pin_b),
      .req_enable           (req_enable),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_direction        (rsp_direction),
      .rsp_position         (rsp_position),
      .rsp_previous_position(rsp_previous_position),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [31:0] next_delta();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         return $urandom_range(0, {16'd0, cfg_debounce});
      end else if (r < 55) begin
         return {16'd0, cfg_debounce} + $urandom_range(0, 3);
      end else if (r < 85) begin
         return {16'd0, cfg_debounce} + $urandom_range(0, {16'd0, cfg_hold} / 3 + 1);
      end else if (r < 97) begin
         return {16'd0, cfg_hold} + $urandom_range(0, 1);
      end
      return $urandom();
   endfunction

   task automatic track_poll(input logic [31:0] t, input logic pa, input logic pb,
                             input logic en);
      rept_pkg::dir_type dir;
      logic              a_on;
      logic              b_on;
      logic [31:0]       since_sample;
      logic [31:0]       since_edge;
      poll_result_type   res;
      dir = rept_pkg::DIR_NONE;
      since_sample = t - sample_ms;
      since_edge = t - edge_ms;
      if (since_sample >= {16'd0, cfg_debounce}) begin
         a_on = (pa == cfg_active);
         b_on = (pb == cfg_active);
         if (!a_on && a_was_on) begin
            dir = b_on ? rept_pkg::DIR_DEC : rept_pkg::DIR_INC;
            if (since_edge < {16'd0, cfg_hold}) begin
               dir = held_dir;
            end else begin
               held_dir = dir;
            end
            edge_ms = t;
         end
         a_was_on = a_on;
         sample_ms = t;
      end
      if (en) begin
         if (dir == rept_pkg::DIR_NONE) begin
            position_kept = position_now;
         end else if (dir == rept_pkg::DIR_DEC) begin
            if (!cfg_limit_en || $signed(position_now) > $signed(cfg_lower)) begin
               position_now = position_now - {1'b0, cfg_step};
            end
         end else if (dir == rept_pkg::DIR_INC) begin
            if (!cfg_limit_en || $signed(position_now) < $signed(cfg_upper)) begin
               position_now = position_now + {1'b0, cfg_step};
            end
         end
      end
      res.direction = dir;
      res.position = position_now;
      res.previous = position_kept;
      expected_polls.push_back(res);
   endtask

   task automatic send_poll(input logic [31:0] t, input logic pa, input logic pb,
                            input logic en);
      int unsigned n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         n = pick_gap();
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_time_ms <= t;
      req_pin_a <= pa;
      req_pin_b <= pb;
      req_enable <= en;
      do @(posedge clock); while (req_stall);
      track_poll(t, pa, pb, en);
   endtask

   task automatic poll_after(input logic [31:0] delta, input logic pa, input logic pb,
                             input logic en);
      clock_ms = clock_ms + delta;
      send_poll(clock_ms, pa, pb, en);
   endtask

   task automatic write_reg(input rept_pkg::csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rept_pkg::CSR_ACTIVE_LEVEL:   cfg_active = data[0];
         rept_pkg::CSR_DEBOUNCE_MS:    cfg_debounce = data;
         rept_pkg::CSR_ERROR_HOLD_MS:  cfg_hold = data;
         rept_pkg::CSR_LIMIT_ENABLE:   cfg_limit_en = data[0];
         rept_pkg::CSR_LOWER_LIMIT:    cfg_lower = data;
         rept_pkg::CSR_UPPER_LIMIT:    cfg_upper = data;
         rept_pkg::CSR_STEP_SIZE:      cfg_step = data[14:0];
         rept_pkg::CSR_START_POSITION: ;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_polls.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // one detent as a gray-code walk of the asserted levels
   task automatic turn_knob(input bit increment);
      logic [1:0] walk [4];
      logic       pa;
      logic       pb;
      if (increment) begin
         walk[0] = 2'b01; walk[1] = 2'b11; walk[2] = 2'b10; walk[3] = 2'b00;
      end else begin
         walk[0] = 2'b10; walk[1] = 2'b11; walk[2] = 2'b01; walk[3] = 2'b00;
      end
      for (int i = 0; i < 4; i++) begin
         pa = walk[i][1] ? cfg_active : ~cfg_active;
         pb = walk[i][0] ? cfg_active : ~cfg_active;
         poll_after(next_delta(), pa, pb, $urandom_range(0, 9) != 0);
      end
   endtask

   task automatic run_mix(input int unsigned polls);
      int unsigned sent;
      int unsigned n;
      sent = 0;
      while (sent < polls) begin
         if ($urandom_range(0, 4) != 0) begin
            n = $urandom_range(1, 3);
            repeat (n) turn_knob(1'($urandom_range(0, 1)));
            sent += 4 * n;
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               poll_after(($urandom_range(0, 9) == 0) ? $urandom() : next_delta(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            sent += n;
         end
      end
   endtask

   task automatic test_directed();
      quiet = 1;
      settle();
      send_poll(32'd0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd10, 1'b1, 1'b1, 1'b1);
      // edge right after reset repeats an empty held direction
      send_poll(32'd20, 1'b0, 1'b1, 1'b1);
      send_poll(32'd21, 1'b1, 1'b1, 1'b1);
      send_poll(32'd300, 1'b1, 1'b0, 1'b1);
      send_poll(32'd600, 1'b0, 1'b1, 1'b1);
      send_poll(32'd610, 1'b1, 1'b1, 1'b1);
      send_poll(32'd650, 1'b0, 1'b0, 1'b1);
      send_poll(32'd700, 1'b1, 1'b0, 1'b1);
      // edge exactly at the end of the hold window
      send_poll(32'd850, 1'b0, 1'b0, 1'b1);
      send_poll(32'd852, 1'b1, 1'b1, 1'b1);
      send_poll(32'd1400, 1'b1, 1'b1, 1'b0);
      send_poll(32'd1700, 1'b0, 1'b0, 1'b0);
      send_poll(32'd1701, 1'b1, 1'b0, 1'b0);
      send_poll(32'hffff_fff0, 1'b1, 1'b1, 1'b1);
      send_poll(32'hffff_ffff, 1'b0, 1'b1, 1'b1);
      send_poll(32'd5, 1'b1, 1'b0, 1'b1);
      send_poll(32'd150, 1'b0, 1'b0, 1'b1);
      send_poll(32'd400, 1'b0, 1'b0, 1'b1);
      clock_ms = 32'd400;
   endtask

   task automatic test_active_low_fast();
      quiet = 0;
      settle();
      write_reg(rept_pkg::CSR_ACTIVE_LEVEL, 16'd0);
      write_reg(rept_pkg::CSR_DEBOUNCE_MS, 16'd0);
      write_reg(rept_pkg::CSR_ERROR_HOLD_MS, 16'd0);
      run_mix(150);
   endtask

   task automatic test_limit_overshoot();
      quiet = 0;
      settle();
      write_reg(rept_pkg::CSR_ACTIVE_LEVEL, 16'd1);
      write_reg(rept_pkg::CSR_DEBOUNCE_MS, 16'd3);
      write_reg(rept_pkg::CSR_ERROR_HOLD_MS, 16'd40);
      write_reg(rept_pkg::CSR_LIMIT_ENABLE, 16'd1);
      write_reg(rept_pkg::CSR_LOWER_LIMIT, 16'hfffb);
      write_reg(rept_pkg::CSR_UPPER_LIMIT, 16'd5);
      write_reg(rept_pkg::CSR_STEP_SIZE, 16'd3);
      run_mix(200);
   endtask

   task automatic test_slow_timing();
      quiet = 1;
      settle();
      write_reg(rept_pkg::CSR_DEBOUNCE_MS, 16'hffff);
      write_reg(rept_pkg::CSR_ERROR_HOLD_MS, 16'hffff);
      write_reg(rept_pkg::CSR_LIMIT_ENABLE, 16'd0);
      write_reg(rept_pkg::CSR_STEP_SIZE, 16'h7fff);
      run_mix(100);
   endtask

   task automatic test_blocked_and_zero_step();
      quiet = 0;
      settle();
      write_reg(rept_pkg::CSR_DEBOUNCE_MS, 16'd1);
      write_reg(rept_pkg::CSR_ERROR_HOLD_MS, 16'd5);
      write_reg(rept_pkg::CSR_LIMIT_ENABLE, 16'd1);
      write_reg(rept_pkg::CSR_LOWER_LIMIT, 16'h7fff);
      write_reg(rept_pkg::CSR_UPPER_LIMIT, 16'h8000);
      write_reg(rept_pkg::CSR_STEP_SIZE, 16'd9);
      run_mix(100);
      settle();
      write_reg(rept_pkg::CSR_LIMIT_ENABLE, 16'd0);
      write_reg(rept_pkg::CSR_STEP_SIZE, 16'd0);
      write_reg(rept_pkg::CSR_START_POSITION, 16'h8000);
      run_mix(40);
   endtask

   task automatic test_time_wrap();
      quiet = 0;
      settle();
      write_reg(rept_pkg::CSR_DEBOUNCE_MS, 16'd4);
      write_reg(rept_pkg::CSR_ERROR_HOLD_MS, 16'd100);
      write_reg(rept_pkg::CSR_STEP_SIZE, 16'd2);
      clock_ms = 32'hffff_ff00;
      run_mix(100);
   endtask

   task automatic test_random_settings();
      int lim;
      repeat (6) begin
         quiet = ($urandom_range(0, 3) == 0);
         settle();
         write_reg(rept_pkg::CSR_ACTIVE_LEVEL, 16'($urandom()));
         write_reg(rept_pkg::CSR_DEBOUNCE_MS, 16'(($urandom_range(0, 5) == 0) ?
                   $urandom() : $urandom_range(0, 8)));
         write_reg(rept_pkg::CSR_ERROR_HOLD_MS, 16'(($urandom_range(0, 5) == 0) ?
                   $urandom() : $urandom_range(0, 300)));
         write_reg(rept_pkg::CSR_LIMIT_ENABLE, 16'($urandom()));
         lim = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 100) - 50;
         write_reg(rept_pkg::CSR_LOWER_LIMIT, lim[15:0]);
         lim = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 100) - 50;
         write_reg(rept_pkg::CSR_UPPER_LIMIT, lim[15:0]);
         write_reg(rept_pkg::CSR_STEP_SIZE, 16'(($urandom_range(0, 4) == 0) ?
                   $urandom() : $urandom_range(0, 5)));
         write_reg(rept_pkg::CSR_START_POSITION, 16'($urandom()));
         run_mix(110);
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_polls.size() == 0) begin
            flag_mismatch("item with nothing expected", 32'd0, {30'd0, rsp_direction});
         end else begin
            next_result = expected_polls.pop_front();
            if (rsp_direction !== next_result.direction) begin
               flag_mismatch("direction", {30'd0, next_result.direction},
                             {30'd0, rsp_direction});
            end
            if (rsp_position !== next_result.position) begin
               flag_mismatch("position", {16'd0, next_result.position},
                             {16'd0, rsp_position});
            end
            if (rsp_previous_position !== next_result.previous) begin
               flag_mismatch("previous_position", {16'd0, next_result.previous},
                             {16'd0, rsp_previous_position});
            end
         end
      end
   end

   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_time_ms = 32'd0;
      req_pin_a = 1'b0;
      req_pin_b = 1'b0;
      req_enable = 1'b0;
      csr_valid = 1'b0;
      csr_index = rept_pkg::CSR_ACTIVE_LEVEL;
      csr_wdata = 16'd0;
      quiet = 1;
      clock_ms = 32'd0;
      cfg_active = rept_pkg::RST_ACTIVE_LEVEL;
      cfg_debounce = rept_pkg::RST_DEBOUNCE_MS;
      cfg_hold = rept_pkg::RST_ERROR_HOLD_MS;
      cfg_limit_en = rept_pkg::RST_LIMIT_ENABLE;
      cfg_lower = rept_pkg::RST_LOWER_LIMIT;
      cfg_upper = rept_pkg::RST_UPPER_LIMIT;
      cfg_step = rept_pkg::RST_STEP_SIZE;
      a_was_on = 1'b0;
      held_dir = rept_pkg::DIR_NONE;
      sample_ms = 32'd0;
      edge_ms = 32'd0;
      position_now = rept_pkg::RST_POSITION;
      position_kept = 16'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_active_low_fast();
      test_limit_overshoot();
      test_slow_timing();
      test_blocked_and_zero_step();
      test_time_wrap();
      test_random_settings();
      settle();

      if (mismatches == 0 && expected_polls.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
